// ===== rtl/natpt_pkg.sv =====
// natpt_pkg: constants and shared types of the address and port translation table
// no dependencies; used by the entry cell, the top level, the checker and the testbench
package natpt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [15:0] FIRST_PUBLIC_PORT = 16'd81;

	// apb register map
	localparam int ADDR_W = 2;
	localparam logic [ADDR_W-1:0] REG_PUBLIC_IP = 2'd0;

	// search transaction that walks the row of entry cells
	typedef struct packed {
		logic             vld;
		logic             inbound;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [31:0]      hit_addr;
		logic [15:0]      hit_port;
		logic [31:0]      src_ip;
		logic [31:0]      dst_ip;
		logic [15:0]      src_port;
		logic [15:0]      dst_port;
	} natpt_tok_t;

	// entry write broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      addr;
		logic [15:0]      port;
	} natpt_wr_t;

endpackage

// ===== rtl/natpt_ifs.sv =====
// natpt_ifs: valid/ready channel interfaces for packet headers in and out
// depends on nothing but the field widths of the headers
interface natpt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] src_port;
	logic [15:0] dst_port;

	modport source (output valid, src_ip, dst_ip, src_port, dst_port, input ready);
	modport sink (input valid, src_ip, dst_ip, src_port, dst_port, output ready);
endinterface

interface natpt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_src_ip;
	logic [31:0] out_dst_ip;
	logic [15:0] out_src_port;
	logic [15:0] out_dst_port;
	logic        drop;

	modport source (output valid, out_src_ip, out_dst_ip, out_src_port, out_dst_port, drop,
		input ready);
	modport sink (input valid, out_src_ip, out_dst_ip, out_src_port, out_dst_port, drop,
		output ready);
endinterface

// ===== rtl/natpt_cell.sv =====
// natpt_cell: one table entry, compares the passing search transaction and hands it on
// depends on natpt_pkg for the transaction and write types
module natpt_cell
	import natpt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  natpt_wr_t        wr,
	input  natpt_tok_t       tok_i,
	output natpt_tok_t       tok_o
);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic [16:0] pub_port;
	logic        match;
	natpt_tok_t  tok_d;
	natpt_tok_t  tok_q;

	// entry valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr.idx == idx) begin
			valid_q <= 1'b1;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == idx) begin
			addr_q <= wr.addr;
			port_q <= wr.port;
		end
	end

	// inbound looks at our public port, outbound at the lan address and port
	assign pub_port = {1'b0, FIRST_PUBLIC_PORT} + 17'(idx);
	always_comb begin
		if (tok_i.inbound) begin
			match = ({1'b0, tok_i.dst_port} == pub_port);
		end else begin
			match = (addr_q == tok_i.src_ip) && (port_q == tok_i.src_port);
		end
		match = match && valid_q && tok_i.vld && !tok_i.hit;
	end

	// mark the hit on the passing transaction
	always_comb begin
		tok_d = tok_i;
		if (match) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_idx  = idx;
			tok_d.hit_addr = addr_q;
			tok_d.hit_port = port_q;
		end
	end

	// hand the transaction to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== rtl/nat_port_translation_table_unit.sv =====
// a header passes the input register, each entry cell register and the pending register
// on its way to the output register; only one header walks the entry cells at a time, and
// the next one is taken once the previous result moves to the output, while it still waits there
// reset: arst_n clears the entry count, all entry valid flags and public_ip to zero
// depends on natpt_pkg, natpt_ifs and natpt_cell
module nat_port_translation_table_unit
	import natpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	natpt_in_if.sink          pkt_in,
	natpt_out_if.source       pkt_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0]      public_ip_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	natpt_tok_t       head_d;
	natpt_tok_t       head_q;
	natpt_tok_t       pend_q;
	natpt_tok_t       link [TABLE_ENTRIES+1];
	natpt_wr_t        wr;
	logic             accept;
	logic             move;
	logic             full;
	logic             drop;
	logic             out_vld_q;
	logic [31:0]      out_src_ip_q;
	logic [31:0]      out_dst_ip_q;
	logic [15:0]      out_src_port_q;
	logic [15:0]      out_dst_port_q;
	logic             out_drop_q;
	logic [31:0]      res_src_ip;
	logic [31:0]      res_dst_ip;
	logic [15:0]      res_src_port;
	logic [15:0]      res_dst_port;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == REG_PUBLIC_IP) ? public_ip_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			public_ip_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr == REG_PUBLIC_IP) begin
			public_ip_q <= pwdata;
		end
	end

	// input side
	assign pkt_in.ready = !busy_q;
	assign accept = pkt_in.valid && !busy_q;

	always_comb begin
		head_d = '0;
		if (accept) begin
			head_d.vld      = 1'b1;
			head_d.inbound  = (pkt_in.dst_ip == public_ip_q);
			head_d.src_ip   = pkt_in.src_ip;
			head_d.dst_ip   = pkt_in.dst_ip;
			head_d.src_port = pkt_in.src_port;
			head_d.dst_port = pkt_in.dst_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_d;
		end
	end

	// row of entry cells
	assign link[0] = head_q;
	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		natpt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(k)),
			.wr     (wr),
			.tok_i  (link[k]),
			.tok_o  (link[k+1])
		);
	end

	// result decision
	assign full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign drop = !pend_q.hit && (pend_q.inbound || full);
	assign move = pend_q.vld && (!out_vld_q || pkt_out.ready);

	always_comb begin
		res_src_ip   = 32'd0;
		res_dst_ip   = 32'd0;
		res_src_port = 16'd0;
		res_dst_port = 16'd0;
		if (!drop) begin
			if (pend_q.inbound) begin
				res_src_ip   = pend_q.src_ip;
				res_dst_ip   = pend_q.hit_addr;
				res_src_port = pend_q.src_port;
				res_dst_port = pend_q.hit_port;
			end else begin
				res_src_ip   = public_ip_q;
				res_dst_ip   = pend_q.dst_ip;
				res_dst_port = pend_q.dst_port;
				if (pend_q.hit) begin
					res_src_port = FIRST_PUBLIC_PORT + 16'(pend_q.hit_idx);
				end else begin
					res_src_port = FIRST_PUBLIC_PORT + 16'(count_q);
				end
			end
		end
	end

	// append a new entry on an outbound miss while the table is not full
	always_comb begin
		wr.en   = move && !pend_q.inbound && !pend_q.hit && !full;
		wr.idx  = count_q[IDX_W-1:0];
		wr.addr = pend_q.src_ip;
		wr.port = pend_q.src_port;
	end

	// control: busy flag, pending result and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (link[TABLE_ENTRIES].vld) begin
				pend_q <= link[TABLE_ENTRIES];
			end else if (move) begin
				pend_q.vld <= 1'b0;
			end
			if (wr.en) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (move) begin
			out_vld_q <= 1'b1;
		end else if (pkt_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_src_ip_q   <= res_src_ip;
			out_dst_ip_q   <= res_dst_ip;
			out_src_port_q <= res_src_port;
			out_dst_port_q <= res_dst_port;
			out_drop_q     <= drop;
		end
	end

	assign pkt_out.valid        = out_vld_q;
	assign pkt_out.out_src_ip   = out_src_ip_q;
	assign pkt_out.out_dst_ip   = out_dst_ip_q;
	assign pkt_out.out_src_port = out_src_port_q;
	assign pkt_out.out_dst_port = out_dst_port_q;
	assign pkt_out.drop         = out_drop_q;

endmodule

// ===== tb/natpt_checker.sv =====
// natpt_checker: watches the header channels and the apb port of the translation table,
// predicts every rewritten header and compares it with what the block delivers
// depends on natpt_pkg and the natpt_in_if / natpt_out_if interfaces
module natpt_checker
	import natpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	natpt_in_if               in_mon,
	natpt_out_if              out_mon,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output int                fail_count,
	output int                pending,
	output int                results_seen,
	output int                drops_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic        drop;
	} rewrite_t;

	// shadow of the translation state
	logic [31:0] wan_ip;
	int          flow_count;
	logic [31:0] flow_addr [TABLE_ENTRIES];
	logic [15:0] flow_port [TABLE_ENTRIES];
	rewrite_t    rewrite_q [$];

	// rewrite one header and update the shadow table like the block does
	function automatic rewrite_t translate_header(input logic [31:0] sip, input logic [31:0] dip,
		input logic [15:0] sport, input logic [15:0] dport);
		rewrite_t r;
		logic     found;
		r = '0;
		found = 1'b0;
		if (dip == wan_ip) begin
			// inbound: public port selects the entry
			for (int k = 0; k < flow_count; k++) begin
				if (!found && (16'(FIRST_PUBLIC_PORT + k) == dport)) begin
					found = 1'b1;
					r.src_ip = sip;
					r.src_port = sport;
					r.dst_ip = flow_addr[k];
					r.dst_port = flow_port[k];
				end
			end
			if (!found)
				r.drop = 1'b1;
		end else begin
			// outbound: find the flow or append it
			for (int k = 0; k < flow_count; k++) begin
				if (!found && flow_addr[k] == sip && flow_port[k] == sport) begin
					found = 1'b1;
					r.src_ip = wan_ip;
					r.src_port = 16'(FIRST_PUBLIC_PORT + k);
					r.dst_ip = dip;
					r.dst_port = dport;
				end
			end
			if (!found) begin
				if (flow_count >= TABLE_ENTRIES) begin
					r.drop = 1'b1;
				end else begin
					flow_addr[flow_count] = sip;
					flow_port[flow_count] = sport;
					r.src_ip = wan_ip;
					r.src_port = 16'(FIRST_PUBLIC_PORT + flow_count);
					r.dst_ip = dip;
					r.dst_port = dport;
					flow_count++;
				end
			end
		end
		return r;
	endfunction

	function automatic int field_differs(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// compare delivered headers in order, predict each accepted one
	always @(posedge clk or negedge arst_n) begin : watch
		rewrite_t want;
		rewrite_t got;
		int       errs;
		if (!arst_n) begin
			wan_ip = '0;
			flow_count = 0;
			rewrite_q.delete();
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
			drops_seen <= 0;
		end else begin
			errs = 0;
			// result transaction
			if (out_mon.valid && out_mon.ready) begin
				got.src_ip = out_mon.out_src_ip;
				got.dst_ip = out_mon.out_dst_ip;
				got.src_port = out_mon.out_src_port;
				got.dst_port = out_mon.out_dst_port;
				got.drop = out_mon.drop;
				if (rewrite_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, got);
					errs++;
				end else begin
					want = rewrite_q.pop_front();
					errs += field_differs("out_src_ip", want.src_ip, got.src_ip);
					errs += field_differs("out_dst_ip", want.dst_ip, got.dst_ip);
					errs += field_differs("out_src_port", 32'(want.src_port), 32'(got.src_port));
					errs += field_differs("out_dst_port", 32'(want.dst_port), 32'(got.dst_port));
					errs += field_differs("drop", 32'(want.drop), 32'(got.drop));
				end
				results_seen <= results_seen + 1;
				if (got.drop)
					drops_seen <= drops_seen + 1;
			end
			// register write
			if (psel && penable && pwrite && pready && paddr == REG_PUBLIC_IP)
				wan_ip = pwdata;
			// header transaction
			if (in_mon.valid && in_mon.ready)
				rewrite_q.push_back(translate_header(in_mon.src_ip, in_mon.dst_ip,
					in_mon.src_port, in_mon.dst_port));
			pending <= rewrite_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus for the address and port translation table: apb setup of the public
// address, directed and random headers, random input gaps and output stalls, final verdict
// depends on natpt_pkg, natpt_ifs, the block itself and natpt_checker
module tb_top
	import natpt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_SIZE = 24;
	localparam int PHASE_ITEMS = 270;
	localparam int PRESSURE_AT = 500;
	localparam int PRESSURE_CYCLES = 400;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = TABLE_ENTRIES + 3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int          fail_count;
	int          pending;
	int          results_seen;
	int          drops_seen;
	int          sent_count = 0;
	int          settings_used = 0;
	logic [31:0] wan_addr;
	logic [31:0] pool_ip [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];

	natpt_in_if  in_ch();
	natpt_out_if out_ch();

	nat_port_translation_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_in(in_ch),
		.pkt_out(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	natpt_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending),
		.results_seen(results_seen),
		.drops_seen(drops_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 20);
		return $urandom_range(30, 90);
	endfunction

	// one header transaction, then an optional idle gap
	task automatic send_header(input logic [31:0] sip, input logic [31:0] dip,
		input logic [15:0] sport, input logic [15:0] dport, input int gap);
		in_ch.valid <= 1'b1;
		in_ch.src_ip <= sip;
		in_ch.dst_ip <= dip;
		in_ch.src_port <= sport;
		in_ch.dst_port <= dport;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent_count++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// apb setup and access cycles
	task automatic write_public_ip(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_PUBLIC_IP;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		wan_addr = value;
		settings_used++;
		@(posedge clk);
	endtask

	// stop offering, let every expected result arrive, then let the pipeline settle
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off once the sender is well underway
	initial begin : receiver
		int  gap;
		logic held_off;
		held_off = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!held_off && sent_count >= PRESSURE_AT) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// cycles in which nothing moves on any port
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] settings [4];
		logic        burst;
		int          kind;
		int          p;

		in_ch.valid <= 1'b0;
		in_ch.src_ip <= '0;
		in_ch.dst_ip <= '0;
		in_ch.src_port <= '0;
		in_ch.dst_port <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		wan_addr = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, first flows, inbound hits and misses, full table
		write_public_ip(32'h0000_0000);
		send_header(32'h0A00_0001, 32'h0000_0000, 16'd1234, 16'd81, pick_gap());
		pool_ip[0] = 32'h0000_0000;
		pool_port[0] = 16'h0000;
		send_header(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, pick_gap());
		pool_ip[1] = 32'hFFFF_FFFF;
		pool_port[1] = 16'hFFFF;
		send_header(32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 16'h0000, pick_gap());
		send_header(32'h0000_0000, 32'h0808_0808, 16'h0000, 16'd53, pick_gap());
		send_header(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'd81, pick_gap());
		send_header(32'h1234_5678, 32'h0000_0000, 16'd7, 16'd82, pick_gap());
		send_header(32'h1234_5678, 32'h0000_0000, 16'd7, 16'd83, pick_gap());
		send_header(32'h1234_5678, 32'h0000_0000, 16'd7, 16'd80, pick_gap());
		send_header(32'h1234_5678, 32'h0000_0000, 16'd7, 16'h0000, pick_gap());
		send_header(32'h1234_5678, 32'h0000_0000, 16'd7, 16'hFFFF, pick_gap());
		// same address as the first flow, different port: a new entry
		pool_ip[2] = 32'h0000_0000;
		pool_port[2] = 16'd1;
		send_header(32'h0000_0000, 32'h0000_0002, 16'd1, 16'd443, pick_gap());
		for (int k = 3; k < POOL_SIZE; k++) begin
			pool_ip[k] = $urandom;
			pool_port[k] = 16'($urandom_range(0, 65535));
		end
		// fill the table and drop one new flow too many; inbound on the last port and past it
		for (int k = 3; k <= TABLE_ENTRIES; k++)
			send_header(pool_ip[k], $urandom | 32'h1, pool_port[k],
				16'($urandom_range(0, 65535)), pick_gap());
		send_header($urandom, 32'h0000_0000, 16'd9, 16'(FIRST_PUBLIC_PORT + TABLE_ENTRIES - 1),
			pick_gap());
		send_header($urandom, 32'h0000_0000, 16'd9, 16'(FIRST_PUBLIC_PORT + TABLE_ENTRIES), 1);
		wait_drained();

		// random phases, each under its own public address
		settings[0] = 32'hFFFF_FFFF;
		settings[1] = $urandom;
		settings[2] = 32'h0000_0000;
		settings[3] = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			write_public_ip(settings[ph]);
			burst = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					burst = ($urandom_range(0, 3) == 0);
				kind = $urandom_range(0, 99);
				sip = $urandom;
				dip = $urandom;
				sport = 16'($urandom_range(0, 65535));
				dport = 16'($urandom_range(0, 65535));
				if (kind < 40) begin
					// outbound on a known or pending flow
					p = $urandom_range(0, POOL_SIZE - 1);
					sip = pool_ip[p];
					sport = pool_port[p];
					if (dip == wan_addr)
						dip = ~dip;
				end else if (kind < 75) begin
					// inbound around the public port range
					dip = wan_addr;
					dport = 16'(FIRST_PUBLIC_PORT + $urandom_range(0, TABLE_ENTRIES + 2));
				end else if (kind < 85) begin
					dip = wan_addr;
				end
				send_header(sip, dip, sport, dport,
					(n == PHASE_ITEMS - 1) ? 1 : (burst ? 0 : pick_gap()));
			end
			wait_drained();
		end

		$display("run covered %0d headers under %0d public address settings", sent_count,
			settings_used);
		$display("%0d results compared, %0d of them drops", results_seen, drops_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
